[rtl/lbp_pkg.sv]
// Shared types, sizes and register indexes of the 3x3 local binary pattern operator.
package lbp_pkg;

  localparam int PIXEL_W        = 8;
  localparam int LINE_W         = 2 * PIXEL_W;
  localparam int ROW_W          = 12;
  localparam int COL_W          = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int IMG_WIDTH_W    = 11;
  localparam int IMG_HEIGHT_W   = 13;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int WIDTH_RST      = 640;
  localparam int HEIGHT_RST     = 480;
  localparam int MIN_SIZE       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // Position and flags of the center pixel that one input pixel completes.
  typedef struct packed {
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
    logic             code_valid;
    logic             frame_done;
  } pos_t;

endpackage

[rtl/lbp_position.sv]
// Frame size registers and the raster row/column counters of the LBP operator.
module lbp_position #(
  parameter int MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lbp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             advance,
  input  logic                             frame_start,
  output logic [$clog2(MAX_WIDTH)-1:0]     col,
  output lbp_pkg::pos_t                    pos
);
  import lbp_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int W_RST = (WIDTH_RST < MAX_WIDTH) ? WIDTH_RST : MAX_WIDTH;
  localparam int H_RST = (HEIGHT_RST < MAX_HEIGHT) ? HEIGHT_RST : MAX_HEIGHT;

  logic [CW:0]           w_r, w_cfg;
  logic [RW:0]           h_r, h_cfg;
  logic [CW-1:0]         col_r, col_nxt, cur_c, col_m1;
  logic [RW-1:0]         row_r, row_nxt, cur_r, row_m1;
  logic [CW:0]           c_inc;
  logic [RW:0]           r_inc;
  logic [IMG_WIDTH_W-1:0]  v_w;
  logic [IMG_HEIGHT_W-1:0] v_h;
  logic                  restart;

  // Sizes are saturated to the supported range when they are written.
  assign v_w = cfg_wdata[IMG_WIDTH_W-1:0];
  assign v_h = cfg_wdata[IMG_HEIGHT_W-1:0];

  always_comb begin
    if (32'(v_w) < 32'(MIN_SIZE)) begin
      w_cfg = (CW+1)'(MIN_SIZE);
    end else if (32'(v_w) > 32'(MAX_WIDTH)) begin
      w_cfg = (CW+1)'(MAX_WIDTH);
    end else begin
      w_cfg = (CW+1)'(v_w);
    end
    if (32'(v_h) < 32'(MIN_SIZE)) begin
      h_cfg = (RW+1)'(MIN_SIZE);
    end else if (32'(v_h) > 32'(MAX_HEIGHT)) begin
      h_cfg = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_cfg = (RW+1)'(v_h);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= (CW+1)'(W_RST);
      h_r <= (RW+1)'(H_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  w_r <= w_cfg;
        REG_IMAGE_HEIGHT: h_r <= h_cfg;
        default: ;
      endcase
    end
  end

  // A counter outside the current size restarts the frame, as does frame_start.
  always_comb begin
    restart = frame_start || ({1'b0, col_r} >= w_r) || ({1'b0, row_r} >= h_r);
    cur_c   = restart ? '0 : col_r;
    cur_r   = restart ? '0 : row_r;
    c_inc   = {1'b0, cur_c} + 1'b1;
    r_inc   = {1'b0, cur_r} + 1'b1;
    if (c_inc >= w_r) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_r) ? '0 : r_inc[RW-1:0];
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = cur_r;
    end
    col_m1 = cur_c - 1'b1;
    row_m1 = cur_r - 1'b1;
    col    = cur_c;
    pos.center_row = (cur_r == '0) ? '0 : ROW_W'(row_m1);
    pos.center_col = (cur_c == '0) ? '0 : COL_W'(col_m1);
    pos.code_valid = (32'(cur_r) >= 32'd2) && (32'(cur_c) >= 32'd2);
    pos.frame_done = ({1'b0, cur_r} == h_r - 1'b1) && ({1'b0, cur_c} == w_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[rtl/lbp_line_mem.sv]
// Line buffer memory holding the two previous image rows, with write-to-read bypass.
module lbp_line_mem #(
  parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  output logic [lbp_pkg::LINE_W-1:0]    rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
  input  logic [lbp_pkg::LINE_W-1:0]    wr_data
);
  import lbp_pkg::*;

  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] ram_q_r;
  logic [LINE_W-1:0] fwd_data_r;
  logic              fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ram_q_r <= line_mem[rd_addr];
    end
  end

  // A read of the entry written in the same cycle takes the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : ram_q_r;

endmodule

[rtl/lbp_window.sv]
// 3x3 window shift register and the eight neighbor comparisons of the LBP code.
module lbp_window (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [lbp_pkg::PIXEL_W-1:0]  new_top,
  input  logic [lbp_pkg::PIXEL_W-1:0]  new_mid,
  input  logic [lbp_pkg::PIXEL_W-1:0]  new_bot,
  input  logic                         code_valid,
  output logic [lbp_pkg::PIXEL_W-1:0]  code
);
  import lbp_pkg::*;

  // Only the left and middle columns are stored (mid_r, right_r); the right one comes from the inputs.
  logic [PIXEL_W-1:0] mid_r   [3];
  logic [PIXEL_W-1:0] right_r [3];
  logic [PIXEL_W-1:0] ctr;

  always_comb begin
    ctr = right_r[1];
    code = {mid_r[0] > ctr, right_r[0] > ctr, new_top > ctr, new_mid > ctr,
            new_bot > ctr, right_r[2] > ctr, mid_r[2] > ctr, mid_r[1] > ctr};
    if (!code_valid) begin
      code = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        mid_r[k]   <= '0;
        right_r[k] <= '0;
      end
    end else if (advance) begin
      for (int k = 0; k < 3; k++) begin
        mid_r[k] <= right_r[k];
      end
      right_r[0] <= new_top;
      right_r[1] <= new_mid;
      right_r[2] <= new_bot;
    end
  end

endmodule

[rtl/lbp_3x3_operator.sv]
// Top level of the streaming 3x3 local binary pattern operator.
//
// Pixels of an 8-bit grayscale image enter in raster order on the input
// channel, one transfer per pixel; in_frame_start marks pixel (0,0). Every
// input transfer produces exactly one result transfer: the LBP code of the
// center one row up and one column left, its position, and flags that tell
// whether the center is interior and whether it closes the frame.
// The user must write frame width and height through the cfg port only while idle; the block does not enforce it.
//
// A pixel is accepted at an edge where in_valid is high and in_stall low. The
// line buffer memory is read and the middle stage is loaded at that edge, the
// window and code are formed from the middle stage and the memory output, and
// the result register loads when the middle stage advances, which raises
// out_valid; the result transfer happens at a later edge with out_stall low. With
// no stall one pixel is taken every cycle: the memory is read and written once per
// transfer and a bypass covers a read of the column written in the same cycle.
//
// When the receiver raises out_stall the result register holds; in_stall rises
// as soon as the middle stage holds a pixel. Reset clears the counters, sizes
// (640 x 480), window and pipeline; the line memory needs no clearing pass and
// is ready right after reset.
module lbp_3x3_operator #(
  parameter int MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lbp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lbp_pkg::PIXEL_W-1:0]     in_pixel,
  input  logic                            in_frame_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lbp_pkg::PIXEL_W-1:0]     out_lbp_code,
  output logic [lbp_pkg::ROW_W-1:0]       out_center_row,
  output logic [lbp_pkg::COL_W-1:0]       out_center_col,
  output logic                            out_code_valid,
  output logic                            out_frame_done,
  input  logic                            cfg_we,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lbp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic               in_accept;
  logic               s1_adv;
  logic [CW-1:0]      col;
  pos_t               pos;
  logic               s1_valid_r;
  logic [PIXEL_W-1:0] s1_pixel_r;
  logic [CW-1:0]      s1_col_r;
  pos_t               s1_pos_r;
  logic [LINE_W-1:0]  rd_data;
  logic [PIXEL_W-1:0] code_nxt;
  logic               out_valid_r;
  logic [PIXEL_W-1:0] out_code_r;
  pos_t               out_pos_r;

  assign in_accept = in_valid && !in_stall;
  // The middle stage moves on whenever the result register is free.
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;

  lbp_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_position (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .advance     (in_accept),
    .frame_start (in_frame_start),
    .col         (col),
    .pos         (pos)
  );

  // Each memory word holds {row two above, row above} for one column. The
  // word is rewritten as the pixel leaves the middle stage.
  lbp_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data ({rd_data[PIXEL_W-1:0], s1_pixel_r})
  );

  lbp_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (s1_adv),
    .new_top    (rd_data[LINE_W-1:PIXEL_W]),
    .new_mid    (rd_data[PIXEL_W-1:0]),
    .new_bot    (s1_pixel_r),
    .code_valid (s1_pos_r.code_valid),
    .code       (code_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel_r <= in_pixel;
      s1_col_r   <= col;
      s1_pos_r   <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_code_r <= code_nxt;
      out_pos_r  <= s1_pos_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lbp_code   = out_code_r;
  assign out_center_row = out_pos_r.center_row;
  assign out_center_col = out_pos_r.center_col;
  assign out_code_valid = out_pos_r.code_valid;
  assign out_frame_done = out_pos_r.frame_done;

  // Input backpressure only comes from a full middle stage behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("in_stall without a stalled result behind the middle stage");

  a_adv_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("middle stage advanced but no result was registered");

  a_interior_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_code_valid) |-> (out_center_row != '0 && out_center_col != '0))
    else $error("interior code reported for a border center");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_code_valid) |-> (out_lbp_code == '0))
    else $error("nonzero code on a border result");

endmodule
